// ===== rtl/rect_difference_span_emitter_macros.svh =====
// assertion macros for the rectangle difference span emitter
`ifndef RECT_DIFFERENCE_SPAN_EMITTER_MACROS_SVH
`define RECT_DIFFERENCE_SPAN_EMITTER_MACROS_SVH

// property holds in the same cycle
`define RDE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define RDE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rde_pkg.sv =====
// shared constants and controller/datapath types for the span emitter
`default_nettype none
package rde_pkg;

  localparam int CoordW = 12;
  localparam int MapW   = 13;
  localparam int IdxW   = 24;
  localparam int LenW   = 6;

  localparam logic [CoordW-1:0] MAX_SIDE      = 12'd32;
  localparam logic [MapW-1:0]   MAP_WIDTH_RST = 13'd1024;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
  } rde_cmd_t;

  typedef struct packed {
    logic out_free;
    logic a_empty;
    logic done_now;
  } rde_sts_t;

endpackage
`default_nettype wire

// ===== rtl/rde_ctrl.sv =====
// controller state machine for the span emitter
`default_nettype none
module rde_ctrl
  import rde_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  rde_sts_t      sts,
  output rde_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SETUP = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd.load  = in_tvalid && (state_r == ST_IDLE);
    cmd.setup = (state_r == ST_SETUP);
    cmd.step  = (state_r == ST_EMIT) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = sts.a_empty ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.done_now) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rde_dp.sv =====
// datapath: rectangle registers, overlap setup, row walk and output register
`default_nettype none
module rde_dp
  import rde_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [95:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        cfg_valid,
  input  wire logic [12:0] cfg_data,
  input  wire logic        out_tready,
  output logic             out_tvalid,
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  output logic             out_tuser,
  input  rde_cmd_t         cmd,
  output rde_sts_t         sts
);

  logic [CoordW-1:0] ax0_r, ax1_r, ay0_r, ay1_r;
  logic [CoordW-1:0] bx0_r, bx1_r, by0_r, by1_r;
  logic              bemp_r;
  logic [MapW-1:0]   mw_r;

  logic [CoordW-1:0] ox0_r, ox1_r, oy0_r, oy1_r;
  logic              ovl_r, over_r, has_l_r, has_r_r;
  logic [IdxW-1:0]   base_r;
  logic [CoordW-1:0] y_r;
  logic              part_r;

  logic              out_valid_r;
  logic [IdxW-1:0]   out_idx_r;
  logic [LenW-1:0]   out_len_r;
  logic              out_over_r;
  logic              out_last_r;

  logic [CoordW-1:0] ox0, ox1, oy0, oy1;
  logic              ovl, over;
  logic [24:0]       prod;
  logic [CoordW-1:0] dx, dy, left_d, right_d, right_col;
  logic              in_ovl, more_rows;
  logic [CoordW:0]   y_p1;
  logic              emit, adv, last;
  logic [CoordW-1:0] col;
  logic [LenW-1:0]   len;
  logic [IdxW-1:0]   idx;

  // overlap setup
  always_comb begin
    ox0  = (ax0_r > bx0_r) ? ax0_r : bx0_r;
    ox1  = (ax1_r < bx1_r) ? ax1_r : bx1_r;
    oy0  = (ay0_r > by0_r) ? ay0_r : by0_r;
    oy1  = (ay1_r < by1_r) ? ay1_r : by1_r;
    ovl  = !bemp_r && (ox0 <= ox1) && (oy0 <= oy1);
    dx   = ax1_r - ax0_r;
    dy   = ay1_r - ay0_r;
    over = (dx >= MAX_SIDE) || (dy >= MAX_SIDE);
    prod = ay0_r * mw_r;
  end

  // span selection for the current row
  always_comb begin
    in_ovl    = ovl_r && (y_r >= oy0_r) && (y_r <= oy1_r);
    y_p1      = {1'b0, y_r} + 13'd1;
    more_rows = (y_r < ay1_r) && (!ovl_r || has_l_r || has_r_r || (ay1_r > oy1_r) ||
                (y_p1 < {1'b0, oy0_r}));
    left_d    = ox0_r - ax0_r;
    right_d   = ax1_r - ox1_r;
    right_col = ox1_r + 12'd1;

    emit = 1'b0;
    adv  = 1'b1;
    last = 1'b0;
    col  = ax0_r;
    len  = dx[LenW-1:0] + 6'd1;
    if (over_r) begin
      emit = 1'b1;
      last = 1'b1;
    end else if (!in_ovl) begin
      emit = 1'b1;
      last = !more_rows;
    end else if (part_r || (!has_l_r && has_r_r)) begin
      emit = 1'b1;
      col  = right_col;
      len  = right_d[LenW-1:0];
      last = !more_rows;
    end else if (has_l_r) begin
      emit = 1'b1;
      len  = left_d[LenW-1:0];
      if (has_r_r) begin
        adv = 1'b0;
      end else begin
        last = !more_rows;
      end
    end
    idx = base_r + {{(IdxW-CoordW){1'b0}}, col};
  end

  always_comb begin
    sts.out_free = !out_valid_r || out_tready;
    sts.a_empty  = (ax0_r > ax1_r) || (ay0_r > ay1_r);
    sts.done_now = over_r || (adv && (y_r == ay1_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mw_r <= MAP_WIDTH_RST;
    end else if (cfg_valid) begin
      mw_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax0_r  <= in_tdata[11:0];
      ax1_r  <= in_tdata[23:12];
      ay0_r  <= in_tdata[35:24];
      ay1_r  <= in_tdata[47:36];
      bx0_r  <= in_tdata[59:48];
      bx1_r  <= in_tdata[71:60];
      by0_r  <= in_tdata[83:72];
      by1_r  <= in_tdata[95:84];
      bemp_r <= in_tuser;
    end
    if (cmd.setup) begin
      ox0_r   <= ox0;
      ox1_r   <= ox1;
      oy0_r   <= oy0;
      oy1_r   <= oy1;
      ovl_r   <= ovl;
      over_r  <= over;
      has_l_r <= ax0_r < ox0;
      has_r_r <= ox1 < ax1_r;
      base_r  <= prod[IdxW-1:0];
      y_r     <= ay0_r;
      part_r  <= 1'b0;
    end else if (cmd.step) begin
      if (adv) begin
        y_r    <= y_r + 12'd1;
        base_r <= base_r + {{(IdxW-MapW){1'b0}}, mw_r};
        part_r <= 1'b0;
      end else begin
        part_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      out_idx_r  <= over_r ? '0 : idx;
      out_len_r  <= over_r ? '0 : len;
      out_over_r <= over_r;
      out_last_r <= last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_len_r, out_idx_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_over_r;

endmodule
`default_nettype wire

// ===== rtl/rect_difference_span_emitter.sv =====
// top level of the rectangle difference span emitter
// an accepted item is loaded into the rectangle registers, then the overlap setup is registered,
// then the row walk steps: one step per row of A, one more per row with spans on both sides of B,
// each step waiting while the output register holds an untaken span; an oversize A takes one step
// the row walk holds one item at a time; the next item is taken once the walk ends
// reset (synchronous, active low) clears control and the output valid, map_width to 1024
`default_nettype none
`include "rect_difference_span_emitter_macros.svh"
module rect_difference_span_emitter
  import rde_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // a_min_x, a_max_x, a_min_y, a_max_y, b_min_x, b_max_x, b_min_y, b_max_y
  input  wire logic [95:0] in_tdata,
  // b_empty
  input  wire logic        in_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // start_index, span_length, zero fill
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  // oversize
  output logic             out_tuser
);

  rde_cmd_t cmd;
  rde_sts_t sts;
  logic     len_ok;

  assign cfg_ready = 1'b1;

  rde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rde_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  assign len_ok = (out_tdata[29:24] != 6'd0) && ({6'd0, out_tdata[29:24]} <= MAX_SIDE);

  `RDE_ASSERT(a_over_last, (out_tvalid && out_tuser) |-> out_tlast, "oversize item not last")
  `RDE_ASSERT(a_over_zero, (out_tvalid && out_tuser) |-> (out_tdata == 32'd0), "oversize payload")
  `RDE_ASSERT(a_len_ok, (out_tvalid && !out_tuser) |-> len_ok, "bad span length")
  `RDE_ASSERT_NEXT(a_no_b2b, in_tvalid && in_tready, !in_tready, "item taken during setup")

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for the rectangle difference span emitter: predicts row spans and checks every result
`timescale 1ns / 100ps
module tb_top
  import rde_pkg::*;
;

  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int PHASE_ITEMS   = 45;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic [CoordW-1:0] a_min_x, a_max_x, a_min_y, a_max_y;
    logic [CoordW-1:0] b_min_x, b_max_x, b_min_y, b_max_y;
    logic              b_empty;
  } rect_t;

  typedef struct {
    logic [IdxW-1:0] start_index;
    logic [LenW-1:0] span_length;
    logic            oversize;
    logic            last;
  } span_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        in_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] cfg_data;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  logic [MapW-1:0] map_width_q = MAP_WIDTH_RST;
  span_t           pending_spans[$];
  int              send_idle_max = 0;
  int              recv_idle_max = 0;
  bit              hold_off = 1'b0;
  int              err_count = 0;
  int              items_sent = 0;
  int              spans_checked = 0;
  int              widths_written = 0;
  int              cycle_count = 0;

  rect_difference_span_emitter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic span_t mk_span(int unsigned row, int unsigned col, int unsigned len);
    span_t s;
    s.start_index = IdxW'(row * map_width_q + col);
    s.span_length = LenW'(len);
    s.oversize    = 1'b0;
    s.last        = 1'b0;
    return s;
  endfunction

  function automatic void predict_row_spans(rect_t r);
    int unsigned ax0, ax1, ay0, ay1, bx0, bx1, by0, by1, ox0, ox1, oy0, oy1, y;
    bit          overlap;
    span_t       s;
    span_t       row_q[$];
    ax0 = 32'(r.a_min_x);
    ax1 = 32'(r.a_max_x);
    ay0 = 32'(r.a_min_y);
    ay1 = 32'(r.a_max_y);
    bx0 = 32'(r.b_min_x);
    bx1 = 32'(r.b_max_x);
    by0 = 32'(r.b_min_y);
    by1 = 32'(r.b_max_y);
    if (ax0 > ax1 || ay0 > ay1) return;
    if (ax1 - ax0 + 1 > MAX_SIDE || ay1 - ay0 + 1 > MAX_SIDE) begin
      s = '{start_index: '0, span_length: '0, oversize: 1'b1, last: 1'b1};
      pending_spans = {pending_spans, s};
      return;
    end
    ox0 = (ax0 > bx0) ? ax0 : bx0;
    ox1 = (ax1 < bx1) ? ax1 : bx1;
    oy0 = (ay0 > by0) ? ay0 : by0;
    oy1 = (ay1 < by1) ? ay1 : by1;
    overlap = !r.b_empty && ox0 <= ox1 && oy0 <= oy1;
    for (y = ay0; y <= ay1; y++) begin
      if (!overlap || y < oy0 || y > oy1) begin
        row_q = {row_q, mk_span(y, ax0, ax1 - ax0 + 1)};
      end else begin
        if (ax0 < ox0) row_q = {row_q, mk_span(y, ax0, ox0 - ax0)};
        if (ox1 < ax1) row_q = {row_q, mk_span(y, ox1 + 1, ax1 - ox1)};
      end
    end
    if (row_q.size() > 0) row_q[$].last = 1'b1;
    pending_spans = {pending_spans, row_q};
  endfunction

  function automatic rect_t mk_rect(int ax0, int ax1, int ay0, int ay1,
                                    int bx0, int bx1, int by0, int by1, bit be);
    rect_t r;
    r.a_min_x = CoordW'(ax0);
    r.a_max_x = CoordW'(ax1);
    r.a_min_y = CoordW'(ay0);
    r.a_max_y = CoordW'(ay1);
    r.b_min_x = CoordW'(bx0);
    r.b_max_x = CoordW'(bx1);
    r.b_min_y = CoordW'(by0);
    r.b_max_y = CoordW'(by1);
    r.b_empty = be;
    return r;
  endfunction

  function automatic int clip_coord(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  function automatic rect_t rand_rect();
    int    kind, bmode, w, h, ax, ay, bx0, bx1, by0, by1;
    rect_t r;
    kind = $urandom_range(0, 19);
    w = (kind < 14) ? $urandom_range(1, 8) : $urandom_range(1, 32);
    h = (kind < 14) ? $urandom_range(1, 8) : $urandom_range(1, 32);
    if (kind == 19) begin
      if ($urandom_range(0, 1)) w = $urandom_range(33, 4096);
      else h = $urandom_range(33, 4096);
    end
    ax = $urandom_range(0, 4096 - w);
    ay = $urandom_range(0, 4096 - h);
    bmode = $urandom_range(0, 9);
    if (bmode < 7) begin
      bx0 = $urandom_range(clip_coord(ax - 2), clip_coord(ax + w));
      bx1 = $urandom_range(bx0, clip_coord(bx0 + w + 1));
      by0 = $urandom_range(clip_coord(ay - 2), clip_coord(ay + h));
      by1 = $urandom_range(by0, clip_coord(by0 + h + 1));
    end else if (bmode == 7) begin
      bx0 = $urandom_range(0, 4095);
      bx1 = $urandom_range(0, 4095);
      by0 = $urandom_range(0, 4095);
      by1 = $urandom_range(0, 4095);
    end else if (bmode == 8) begin
      // b covers all of a
      bx0 = clip_coord(ax - $urandom_range(0, 3));
      bx1 = clip_coord(ax + w - 1 + $urandom_range(0, 3));
      by0 = clip_coord(ay - $urandom_range(0, 3));
      by1 = clip_coord(ay + h - 1 + $urandom_range(0, 3));
    end else begin
      bx0 = $urandom_range(1, 4095);
      bx1 = $urandom_range(0, bx0 - 1);
      by0 = $urandom_range(0, 4095);
      by1 = $urandom_range(0, 4095);
    end
    r = mk_rect(ax, ax + w - 1, ay, ay + h - 1, bx0, bx1, by0, by1,
                $urandom_range(0, 5) == 0);
    if (kind == 18) begin
      r.a_min_x = CoordW'($urandom_range(1, 4095));
      r.a_max_x = CoordW'($urandom_range(0, 32'(r.a_min_x) - 1));
    end
    return r;
  endfunction

  task automatic send_rect(rect_t r);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.b_empty;
    in_tdata  <= {r.b_max_y, r.b_min_y, r.b_max_x, r.b_min_x,
                  r.a_max_y, r.a_min_y, r.a_max_x, r.a_min_x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_row_spans(r);
    items_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_map_width(logic [MapW-1:0] w);
    cfg_data  <= w;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    map_width_q = w;
    widths_written++;
  endtask

  task automatic check_span();
    span_t exp_s;
    span_t got_s;
    got_s.start_index = out_tdata[IdxW-1:0];
    got_s.span_length = out_tdata[IdxW+LenW-1:IdxW];
    got_s.oversize    = out_tuser;
    got_s.last        = out_tlast;
    spans_checked++;
    if (pending_spans.size() == 0) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("unexpected span at cycle %0d: idx %0h len %0d ovs %0b last %0b",
                 cycle_count, got_s.start_index, got_s.span_length, got_s.oversize,
                 got_s.last);
      return;
    end
    exp_s = pending_spans.pop_front();
    if (got_s.start_index !== exp_s.start_index || got_s.span_length !== exp_s.span_length ||
        got_s.oversize !== exp_s.oversize || got_s.last !== exp_s.last) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("mismatch at cycle %0d: exp %0h/%0d/%0b/%0b got %0h/%0d/%0b/%0b",
                 cycle_count, exp_s.start_index, exp_s.span_length, exp_s.oversize,
                 exp_s.last, got_s.start_index, got_s.span_length, got_s.oversize,
                 got_s.last);
    end
  endtask

  task automatic test_special_cases();
    send_idle_max = 4;
    recv_idle_max = 4;
    send_rect(mk_rect(0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_rect(mk_rect(0, 31, 0, 31, 0, 0, 0, 0, 1'b1));
    // oversize, wide then tall
    send_rect(mk_rect(100, 132, 10, 10, 0, 4095, 0, 4095, 1'b0));
    send_rect(mk_rect(7, 7, 0, 4095, 0, 0, 0, 0, 1'b1));
    // inverted a, also when it would be oversize
    send_rect(mk_rect(5, 4, 3, 9, 0, 0, 0, 0, 1'b1));
    send_rect(mk_rect(0, 4095, 4095, 0, 0, 0, 0, 0, 1'b0));
    // inverted b acts like no overlap
    send_rect(mk_rect(20, 25, 20, 22, 24, 21, 20, 22, 1'b0));
    // b covers a, nothing left
    send_rect(mk_rect(40, 45, 40, 44, 39, 46, 40, 44, 1'b0));
    // split in every row, largest result count
    send_rect(mk_rect(0, 31, 0, 31, 10, 20, 0, 31, 1'b0));
    send_rect(mk_rect(100, 110, 50, 55, 90, 104, 52, 53, 1'b0));
    send_rect(mk_rect(100, 110, 50, 55, 105, 300, 49, 51, 1'b0));
    send_rect(mk_rect(100, 110, 50, 55, 111, 120, 50, 55, 1'b0));
    send_rect(mk_rect(4064, 4095, 4064, 4095, 4064, 4095, 4064, 4095, 1'b1));
    send_rect(mk_rect(0, 3, 0, 9, 0, 3, 3, 5, 1'b0));
    drain_results();
  endtask

  task automatic test_map_width_extremes();
    logic [MapW-1:0] widths[4];
    widths = '{13'd0, 13'd8191, 13'd1, 13'd4096};
    foreach (widths[i]) begin
      write_map_width(widths[i]);
      send_rect(mk_rect(4000, 4020, 4090, 4095, 0, 0, 0, 0, 1'b1));
      send_rect(mk_rect(4070, 4095, 4080, 4095, 4075, 4090, 4082, 4093, 1'b0));
      drain_results();
    end
  endtask

  task automatic test_random_rects();
    logic [MapW-1:0] widths[6];
    int              send_max[6];
    int              recv_max[6];
    widths   = '{13'($urandom_range(1, 4096)), 13'd1, 13'd4096, 13'd8191, 13'd0,
                 13'($urandom_range(2, 100))};
    send_max = '{16, 0, 16, 0, 8, 16};
    recv_max = '{16, 0, 0, 16, 8, 16};
    for (int p = 0; p < 6; p++) begin
      write_map_width(widths[p]);
      send_idle_max = send_max[p];
      recv_idle_max = recv_max[p];
      for (int i = 0; i < PHASE_ITEMS; i++) send_rect(rand_rect());
      drain_results();
    end
  endtask

  task automatic test_backpressure();
    send_idle_max = 0;
    recv_idle_max = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 20; i++) send_rect(rand_rect());
    join
  endtask

  // result sink with random stalls
  initial begin : span_sink
    int stall;
    stall = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        check_span();
        stall = $urandom_range(0, recv_idle_max);
      end
      if (hold_off || stall > 0) begin
        out_tready <= 1'b0;
        if (!hold_off) stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d spans still pending", cycle_count,
             pending_spans.size());
    $display("** rect_difference_span_emitter: FAILED **");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_cases();
    test_map_width_extremes();
    test_random_rects();
    test_backpressure();
    drain_results();
    $display("covered %0d rectangle items, %0d spans checked, %0d map_width writes",
             items_sent, spans_checked, widths_written);
    $display("incl. oversize, inverted, empty-difference, 64-span and stalled-output cases");
    if (err_count == 0 && pending_spans.size() == 0) begin
      $display("** rect_difference_span_emitter: PASSED **");
    end else begin
      $display("%0d errors", err_count);
      $display("** rect_difference_span_emitter: FAILED **");
    end
    $finish;
  end

endmodule
